/* hdl/tpdc_pkg.sv */
// Shared types and constants for the touch press duration classifier.
// Holds register indexes, event codes and the configuration bundle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tpdc_pkg;

    localparam int unsigned SampleW = 16;
    localparam int unsigned TimeW   = 32;
    localparam int unsigned EventW  = 3;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDatW = 32;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        REG_BASELINE    = 3'd0,
        REG_THRESHOLD   = 3'd1,
        REG_SHORT_MIN   = 3'd2,
        REG_THEME       = 3'd3,
        REG_HINT        = 3'd4,
        REG_RECONFIG    = 3'd5
    } reg_idx_t;

    // Event codes on the result word
    typedef enum logic [EventW-1:0] {
        EV_NONE  = 3'd0,
        EV_SHORT = 3'd1,
        EV_FIRST = 3'd2,
        EV_HINT  = 3'd3,
        EV_FINAL = 3'd4
    } event_t;

    // Reset values of the configuration registers
    localparam logic [SampleW-1:0] BASELINE_RST  = 16'd0;
    localparam logic [SampleW-1:0] THRESHOLD_RST = 16'd100;
    localparam logic [TimeW-1:0]   SHORT_MIN_RST = 32'd50;
    localparam logic [TimeW-1:0]   THEME_RST     = 32'd3000;
    localparam logic [TimeW-1:0]   HINT_RST      = 32'd6000;
    localparam logic [TimeW-1:0]   RECONFIG_RST  = 32'd10000;

    // Configuration bundle handed from the register file to the core
    typedef struct packed {
        logic [SampleW-1:0] baseline;
        logic [SampleW-1:0] touch_drop;
        logic [TimeW-1:0]   short_min_ms;
        logic [TimeW-1:0]   theme_ms;
        logic [TimeW-1:0]   hint_ms;
        logic [TimeW-1:0]   reconfig_ms;
    } cfg_t;

endpackage

`default_nettype wire

/* hdl/touch_press_duration_classifier.sv */
// Touch press duration classifier: input register, press core, result register.
// An accepted word goes to the input register, its result to the result register.
// Throughput: one word per cycle, set by the core's single compare pass, while
// out_stall does not hold a full result slot.
// Reset (rst_n low, asynchronous): pipeline empty, press state cleared,
// configuration registers return to their defaults. Config port is always ready.
// Depends on tpdc_pkg, tpdc_cfg_regs and tpdc_core.
`timescale 1ns / 1ps
`default_nettype none

module touch_press_duration_classifier (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [tpdc_pkg::SampleW-1:0]  sample,
    input  wire logic [tpdc_pkg::TimeW-1:0]    now_ms,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [tpdc_pkg::EventW-1:0]        event_res,
    output logic [tpdc_pkg::TimeW-1:0]         held_ms,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [tpdc_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [tpdc_pkg::CfgDatW-1:0]  cfg_data
);
    import tpdc_pkg::*;

    cfg_t              cfg;
    logic              in_valid_reg;
    logic [SampleW-1:0] sample_reg;
    logic [TimeW-1:0]  now_reg;
    logic              out_valid_reg;
    logic [EventW-1:0] event_reg;
    logic [TimeW-1:0]  held_reg;
    logic              out_free;
    logic              step;
    logic              in_take;
    event_t            core_event;
    logic [TimeW-1:0]  core_held;

    assign cfg_ready = 1'b1;

    tpdc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Result slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    tpdc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .sample     (sample_reg),
        .now_ms     (now_reg),
        .cfg        (cfg),
        .event_code (core_event),
        .held       (core_held)
    );

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg <= sample;
            now_reg    <= now_ms;
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // Capture the result word
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            event_reg <= core_event;
            held_reg  <= core_held;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = event_reg;
    assign held_ms   = held_reg;

endmodule

`default_nettype wire

/* hdl/tpdc_cfg_regs.sv */
// Configuration register file of the touch press duration classifier.
// Depends on tpdc_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module tpdc_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [tpdc_pkg::CfgIdxW-1:0]  wr_index,
    input  wire logic [tpdc_pkg::CfgDatW-1:0]  wr_data,
    output tpdc_pkg::cfg_t                     cfg
);
    import tpdc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; indexes past the list leave everything alone
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_BASELINE:  cfg_next.baseline        = wr_data[SampleW-1:0];
                REG_THRESHOLD: cfg_next.touch_drop      = wr_data[SampleW-1:0];
                REG_SHORT_MIN: cfg_next.short_min_ms    = wr_data[TimeW-1:0];
                REG_THEME:     cfg_next.theme_ms        = wr_data[TimeW-1:0];
                REG_HINT:      cfg_next.hint_ms         = wr_data[TimeW-1:0];
                REG_RECONFIG:  cfg_next.reconfig_ms     = wr_data[TimeW-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.baseline        <= BASELINE_RST;
            cfg_reg.touch_drop      <= THRESHOLD_RST;
            cfg_reg.short_min_ms    <= SHORT_MIN_RST;
            cfg_reg.theme_ms        <= THEME_RST;
            cfg_reg.hint_ms         <= HINT_RST;
            cfg_reg.reconfig_ms     <= RECONFIG_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hdl/tpdc_core.sv */
// Press tracking core: touch detect, press state and event selection.
// Depends on tpdc_pkg for cfg_t and event codes.
`timescale 1ns / 1ps
`default_nettype none

module tpdc_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          step,
    input  wire logic [tpdc_pkg::SampleW-1:0]  sample,
    input  wire logic [tpdc_pkg::TimeW-1:0]    now_ms,
    input  wire tpdc_pkg::cfg_t                cfg,
    output tpdc_pkg::event_t                   event_code,
    output logic [tpdc_pkg::TimeW-1:0]         held
);
    import tpdc_pkg::*;

    logic             pressed_reg, pressed_next;
    logic             first_reg, first_next;
    logic             hint_reg, hint_next;
    logic             final_reg, final_next;
    logic [TimeW-1:0] start_reg, start_next;

    logic [SampleW:0] drop;
    logic             touched;
    logic [TimeW-1:0] held_now;

    // Touched when the signed drop below baseline exceeds the threshold
    assign drop     = {1'b0, cfg.baseline} - {1'b0, sample};
    assign touched  = !drop[SampleW] && (drop[SampleW-1:0] > cfg.touch_drop);
    assign held_now = now_ms - start_reg;

    // Advance press state and pick at most one event
    always_comb
    begin
        pressed_next = pressed_reg;
        first_next   = first_reg;
        hint_next    = hint_reg;
        final_next   = final_reg;
        start_next   = start_reg;
        event_code   = EV_NONE;
        held         = '0;
        if (touched)
        begin
            if (!pressed_reg)
            begin
                // New press: record start, no event
                pressed_next = 1'b1;
                first_next   = 1'b0;
                hint_next    = 1'b0;
                final_next   = 1'b0;
                start_next   = now_ms;
            end
            else
            begin
                held = held_now;
                if (!first_reg && (held_now >= cfg.theme_ms))
                begin
                    first_next = 1'b1;
                    event_code = EV_FIRST;
                end
                else if (!hint_reg && (held_now >= cfg.hint_ms))
                begin
                    hint_next  = 1'b1;
                    event_code = EV_HINT;
                end
                else if (!final_reg && (held_now >= cfg.reconfig_ms))
                begin
                    final_next = 1'b1;
                    event_code = EV_FINAL;
                end
            end
        end
        else if (pressed_reg)
        begin
            // Release: short press only if EV_FIRST has not fired and held_now reaches short_min_ms
            if (!first_reg && (held_now >= cfg.short_min_ms))
            begin
                event_code = EV_SHORT;
            end
            pressed_next = 1'b0;
            first_next   = 1'b0;
            hint_next    = 1'b0;
            final_next   = 1'b0;
            start_next   = '0;
        end
    end

    // Hold press state; update only when a word is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= 1'b0;
            first_reg   <= 1'b0;
            hint_reg    <= 1'b0;
            final_reg   <= 1'b0;
            start_reg   <= '0;
        end
        else if (step)
        begin
            pressed_reg <= pressed_next;
            first_reg   <= first_next;
            hint_reg    <= hint_next;
            final_reg   <= final_next;
            start_reg   <= start_next;
        end
    end

endmodule

`default_nettype wire
